>>> hdl/lsfe_pkg.sv
// Shared types, constants and the color palette of the LED strip frame engine.
package lsfe_pkg;

  localparam int DRUM_LEDS_DEF      = 9;
  localparam int CLK_STRIP_LEDS_DEF = 10;
  localparam int LEN_W              = 4;

  localparam logic [31:0] CLEAR_WORD      = 32'hE100_0000;
  localparam logic [7:0]  HEADER_BASE     = 8'hE0;
  localparam logic [31:0] END_FRAME_RESET = 32'hFFFF_FFFF;
  localparam logic [7:0]  BRIGHT_MAX      = 8'd31;
  localparam logic [2:0]  STRIP_CLOCK     = 3'd3;

  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_BRIGHT  = 3'd1,
    KIND_SET_ONE = 3'd2,
    KIND_SET_ALL = 3'd3,
    KIND_UPDATE  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    COLOR_RED       = 4'd0,
    COLOR_GREEN     = 4'd1,
    COLOR_BLUE      = 4'd2,
    COLOR_PURPLE    = 4'd3,
    COLOR_WHITE     = 4'd4,
    COLOR_YELLOW    = 4'd5,
    COLOR_TURQUOISE = 4'd6,
    COLOR_PINK      = 4'd7
  } color_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RMW,
    ST_WRITE1,
    ST_RESP,
    ST_UPD_START,
    ST_UPD_LED,
    ST_UPD_END
  } state_t;

  // Return {blue, green, red}; pink differs between the one-LED and all-LED commands.
  function automatic logic [23:0] palette(input logic [3:0] color, input logic all_leds);
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    case (color_t'(color))
      COLOR_RED:       red = 8'd255;
      COLOR_GREEN:     green = 8'd255;
      COLOR_BLUE:      blue = 8'd255;
      COLOR_PURPLE: begin
        red  = 8'd255;
        blue = 8'd255;
      end
      COLOR_WHITE: begin
        red   = 8'd255;
        green = 8'd255;
        blue  = 8'd255;
      end
      COLOR_YELLOW: begin
        red   = 8'd255;
        green = 8'd105;
      end
      COLOR_TURQUOISE: begin
        red   = 8'd127;
        green = 8'd255;
        blue  = 8'd170;
      end
      COLOR_PINK: begin
        red   = 8'd255;
        green = 8'd25;
        blue  = all_leds ? 8'd50 : 8'd25;
      end
      default: red = 8'd0;
    endcase
    return {blue, green, red};
  endfunction

endpackage

>>> hdl/lsfe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lsfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/led_strip_frame_engine.sv
// Strip-wide commands sweep the strip's words and then give their result; set one
// LED reads and writes a single word; an update step gives up to three words: the
// start frame word, the LED word and the end frame word. One item is in work at a time; the
// read-modify-write sweep over the LED memory (one word a cycle) sets the command rate.
// Reset (rst_n low, synchronous) marks every LED word as zero, sets the send position
// to 0 and the end frame word to all ones; no clearing pass is needed.
module led_strip_frame_engine
  import lsfe_pkg::*;
#(
  parameter int DRUM_LEDS      = DRUM_LEDS_DEF,
  parameter int CLK_STRIP_LEDS = CLK_STRIP_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // strip[2:0], color[6:3], led_number[14:7], brightness[22:15]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // ok[0], spi_word[32:1]
  output logic [1:0]  out_tuser,  // has_word[0], frame_done[1]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int TOTAL = 3 * DRUM_LEDS + CLK_STRIP_LEDS;
  localparam int AW    = $clog2(TOTAL);

  state_t state_r, state_nxt;

  logic [2:0]       kind_r;
  logic [2:0]       strip_r;
  logic [3:0]       color_r;
  logic [7:0]       lednum_r;
  logic [7:0]       bright_r;
  logic [AW-1:0]    base_r, base_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] send_pos_r, send_pos_nxt;
  logic             resp_ok_r, resp_ok_nxt;
  logic [31:0]      end_word_r;
  logic [TOTAL-1:0] vld_r;
  logic             vld_q_r;

  logic             out_tvalid_r;
  logic             out_ok_r, out_has_r, out_done_r, out_last_r;
  logic [31:0]      out_word_r;
  logic             load;
  logic             ld_ok, ld_has, ld_done, ld_last;
  logic [31:0]      ld_word;
  logic             can_load;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [31:0]      wr_data, rd_data, rd_word;
  logic             upd_done;

  lsfe_ram #(
    .WIDTH (32),
    .DEPTH (TOTAL)
  ) u_led_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A word never written since reset reads as zero.
  assign rd_word  = vld_q_r ? rd_data : 32'd0;
  assign can_load = !out_tvalid_r || out_tready;
  assign upd_done = ({1'b0, pos_r} + 5'd1) >= {1'b0, len_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_word_r, out_ok_r};
  assign out_tuser  = {out_done_r, out_has_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    send_pos_nxt = send_pos_r;
    resp_ok_nxt  = resp_ok_r;
    rd_en        = 1'b0;
    rd_addr      = base_r;
    wr_en        = 1'b0;
    wr_addr      = base_r + AW'(idx_r);
    wr_data      = rd_word;
    load         = 1'b0;
    ld_ok        = 1'b0;
    ld_has       = 1'b0;
    ld_word      = 32'd0;
    ld_done      = 1'b0;
    ld_last      = 1'b0;

    case (kind_t'(kind_r))
      KIND_CLEAR:   wr_data = CLEAR_WORD;
      KIND_BRIGHT:  wr_data = {HEADER_BASE | {3'd0, bright_r[4:0]}, rd_word[23:0]};
      KIND_SET_ONE: wr_data = {rd_word[31:24], palette(color_r, 1'b0)};
      KIND_SET_ALL: wr_data = {rd_word[31:24], palette(color_r, 1'b1)};
      default:      wr_data = rd_word;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        base_nxt    = AW'(strip_r[1:0]) * AW'(DRUM_LEDS);
        len_nxt     = (strip_r == STRIP_CLOCK) ? LEN_W'(CLK_STRIP_LEDS) : LEN_W'(DRUM_LEDS);
        idx_nxt     = '0;
        resp_ok_nxt = 1'b0;
        rd_addr     = base_nxt;
        state_nxt   = ST_RESP;
        if (strip_r <= STRIP_CLOCK) begin
          case (kind_t'(kind_r))
            KIND_CLEAR, KIND_SET_ALL: begin
              rd_en     = 1'b1;
              state_nxt = ST_RMW;
            end
            KIND_BRIGHT: begin
              if (bright_r <= BRIGHT_MAX) begin
                rd_en     = 1'b1;
                state_nxt = ST_RMW;
              end
            end
            KIND_SET_ONE: begin
              if (lednum_r != 8'd0 && lednum_r <= {4'd0, len_nxt}) begin
                idx_nxt   = LEN_W'(lednum_r - 8'd1);
                rd_addr   = base_nxt + AW'(idx_nxt);
                rd_en     = 1'b1;
                state_nxt = ST_WRITE1;
              end
            end
            KIND_UPDATE: begin
              // A stale position past the end of this strip restarts the frame.
              pos_nxt   = (send_pos_r >= len_nxt) ? '0 : send_pos_r;
              rd_addr   = base_nxt + AW'(pos_nxt);
              rd_en     = 1'b1;
              state_nxt = (pos_nxt == '0) ? ST_UPD_START : ST_UPD_LED;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end

      ST_RMW: begin
        wr_en = 1'b1;
        if (idx_r == len_r - LEN_W'(1)) begin
          resp_ok_nxt = 1'b1;
          state_nxt   = ST_RESP;
        end else begin
          idx_nxt = idx_r + LEN_W'(1);
          rd_addr = base_r + AW'(idx_nxt);
          rd_en   = 1'b1;
        end
      end

      ST_WRITE1: begin
        wr_en       = 1'b1;
        resp_ok_nxt = 1'b1;
        state_nxt   = ST_RESP;
      end

      ST_RESP: begin
        if (can_load) begin
          load      = 1'b1;
          ld_ok     = resp_ok_r;
          ld_last   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_UPD_START: begin
        if (can_load) begin
          load      = 1'b1;
          ld_ok     = upd_done;
          ld_has    = 1'b1;
          state_nxt = ST_UPD_LED;
        end
      end

      ST_UPD_LED: begin
        if (can_load) begin
          load         = 1'b1;
          ld_ok        = upd_done;
          ld_has       = 1'b1;
          ld_word      = rd_word;
          ld_last      = !upd_done;
          send_pos_nxt = upd_done ? '0 : pos_r + LEN_W'(1);
          state_nxt    = upd_done ? ST_UPD_END : ST_IDLE;
        end
      end

      ST_UPD_END: begin
        if (can_load) begin
          load      = 1'b1;
          ld_ok     = 1'b1;
          ld_has    = 1'b1;
          ld_word   = end_word_r;
          ld_done   = 1'b1;
          ld_last   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      send_pos_r   <= '0;
      end_word_r   <= END_FRAME_RESET;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      send_pos_r <= send_pos_nxt;
      if (cfg_wr_en) begin
        end_word_r <= cfg_wr_data;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r   <= in_tuser;
      strip_r  <= in_tdata[2:0];
      color_r  <= in_tdata[6:3];
      lednum_r <= in_tdata[14:7];
      bright_r <= in_tdata[22:15];
    end
    base_r    <= base_nxt;
    len_r     <= len_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    resp_ok_r <= resp_ok_nxt;
    if (rd_en) begin
      vld_q_r <= vld_r[rd_addr];
    end
    if (load) begin
      out_ok_r   <= ld_ok;
      out_has_r  <= ld_has;
      out_word_r <= ld_word;
      out_done_r <= ld_done;
      out_last_r <= ld_last;
    end
  end

endmodule

>>> tb/led_strip_frame_engine_tb.sv
// Testbench for the LED strip frame engine: directed and random commands checked by a scoreboard.
`timescale 1ns / 1ps

module led_strip_frame_engine_tb
  import lsfe_pkg::*;
;

  localparam int LED_COUNT = 3 * DRUM_LEDS_DEF + CLK_STRIP_LEDS_DEF;

  typedef struct packed {
    logic        ok;
    logic        has_word;
    logic [31:0] spi_word;
    logic        frame_done;
    logic        last;
  } spi_result_t;

  class frame_scoreboard;
    logic [31:0] led_words [LED_COUNT];
    logic [3:0]  send_pos;
    logic [31:0] end_frame;
    spi_result_t pending_words[$];
    int unsigned mismatches;

    function new();
      foreach (led_words[i]) led_words[i] = '0;
      send_pos   = '0;
      end_frame  = END_FRAME_RESET;
      mismatches = 0;
    endfunction

    function void set_end_frame(logic [31:0] value);
      end_frame = value;
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    function void push_word(logic ok, logic has, logic [31:0] word, logic done, logic lst);
      spi_result_t r;
      r.ok         = ok;
      r.has_word   = has;
      r.spi_word   = word;
      r.frame_done = done;
      r.last       = lst;
      pending_words.push_back(r);
    endfunction

    // {blue, green, red}; pink is bluer when painting the whole strip
    function logic [23:0] rgb_of(logic [3:0] color, logic all_leds);
      case (color)
        COLOR_RED:       return {8'd0, 8'd0, 8'd255};
        COLOR_GREEN:     return {8'd0, 8'd255, 8'd0};
        COLOR_BLUE:      return {8'd255, 8'd0, 8'd0};
        COLOR_PURPLE:    return {8'd255, 8'd0, 8'd255};
        COLOR_WHITE:     return {8'd255, 8'd255, 8'd255};
        COLOR_YELLOW:    return {8'd0, 8'd105, 8'd255};
        COLOR_TURQUOISE: return {8'd170, 8'd255, 8'd127};
        COLOR_PINK:      return {(all_leds ? 8'd50 : 8'd25), 8'd25, 8'd255};
        default:         return 24'd0;
      endcase
    endfunction

    function void note_item(logic [2:0] kind, logic [2:0] strip, logic [3:0] color,
                            logic [7:0] led_num, logic [7:0] bright);
      int unsigned base;
      int unsigned len;
      int unsigned pos;
      int unsigned n;
      logic [31:0] words [3];
      logic [23:0] rgb;
      logic        done;
      if (strip > STRIP_CLOCK || kind > KIND_UPDATE) begin
        push_word(1'b0, 1'b0, '0, 1'b0, 1'b1);
        return;
      end
      base = strip * DRUM_LEDS_DEF;
      len  = (strip == STRIP_CLOCK) ? CLK_STRIP_LEDS_DEF : DRUM_LEDS_DEF;
      case (kind)
        KIND_CLEAR: begin
          for (int i = 0; i < len; i++) led_words[base + i] = CLEAR_WORD;
          push_word(1'b1, 1'b0, '0, 1'b0, 1'b1);
        end
        KIND_BRIGHT: begin
          if (bright > BRIGHT_MAX) begin
            push_word(1'b0, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < len; i++)
              led_words[base + i] = {HEADER_BASE | bright, led_words[base + i][23:0]};
            push_word(1'b1, 1'b0, '0, 1'b0, 1'b1);
          end
        end
        KIND_SET_ONE: begin
          if (led_num < 1 || led_num > len) begin
            push_word(1'b0, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            pos = base + led_num - 1;
            led_words[pos] = {led_words[pos][31:24], rgb_of(color, 1'b0)};
            push_word(1'b1, 1'b0, '0, 1'b0, 1'b1);
          end
        end
        KIND_SET_ALL: begin
          rgb = rgb_of(color, 1'b1);
          for (int i = 0; i < len; i++)
            led_words[base + i] = {led_words[base + i][31:24], rgb};
          push_word(1'b1, 1'b0, '0, 1'b0, 1'b1);
        end
        default: begin
          // a position left over from a longer strip restarts the frame
          pos = (send_pos >= len) ? 0 : send_pos;
          n   = 0;
          if (pos == 0) begin
            words[n] = '0;
            n++;
          end
          words[n] = led_words[base + pos];
          n++;
          pos++;
          done = (pos >= len);
          if (done) begin
            words[n] = end_frame;
            n++;
            pos = 0;
          end
          send_pos = 4'(pos);
          for (int k = 0; k < n; k++)
            push_word(done, 1'b1, words[k], done && (k == n - 1), k == n - 1);
        end
      endcase
    endfunction

    function void check_result(logic ok, logic has, logic [31:0] word, logic done, logic lst);
      spi_result_t got;
      spi_result_t want;
      got = {ok, has, word, done, lst};
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got ok=%0b has=%0b word=%08h",
                 $time, ok, has, word, " done=%0b last=%0b", done, lst);
        return;
      end
      want = pending_words.pop_front();
      if (got.ok !== want.ok || got.has_word !== want.has_word ||
          got.spi_word !== want.spi_word || got.frame_done !== want.frame_done ||
          got.last !== want.last) begin
        mismatches++;
        $display("%0t: mismatch: expected ok=%0b has=%0b word=%08h done=%0b last=%0b,",
                 $time, want.ok, want.has_word, want.spi_word, want.frame_done, want.last,
                 " got ok=%0b has=%0b word=%08h done=%0b last=%0b",
                 got.ok, got.has_word, got.spi_word, got.frame_done, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  frame_scoreboard sb;
  bit          tx_quiet   = 1'b0;
  bit          rx_quiet   = 1'b0;
  int unsigned stall_left = 0;

  led_strip_frame_engine i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned strip_len(logic [2:0] strip);
    return (strip == STRIP_CLOCK) ? CLK_STRIP_LEDS_DEF : DRUM_LEDS_DEF;
  endfunction

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap(rx_quiet);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_result(out_tdata[0], out_tuser[0], out_tdata[32:1], out_tuser[1], out_tlast);
  end

  task automatic drive_item(logic [2:0] kind, logic [2:0] strip, logic [3:0] color,
                            logic [7:0] led_num, logic [7:0] bright);
    int unsigned gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, bright, led_num, color, strip};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, strip, color, led_num, bright);
  endtask

  task automatic drive_update(logic [2:0] strip);
    drive_item(KIND_UPDATE, strip, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
  endtask

  // hold off until every result is out and the command sweep has surely ended
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_end_frame(logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_end_frame(value);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned r;
    int unsigned steps;
    logic [2:0]  strip;
    logic [2:0]  kind;
    logic [7:0]  led_num;
    logic [7:0]  bright;
    sent = 0;
    while (sent < count) begin
      r     = $urandom_range(0, 99);
      strip = 3'($urandom_range(0, 3));
      if (r < 40) begin
        // whole frame, sometimes cut short
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, strip_len(strip))
                                             : strip_len(strip);
        repeat (steps) drive_update(strip);
        sent += steps;
      end else if (r < 70) begin
        kind    = 3'($urandom_range(KIND_CLEAR, KIND_SET_ALL));
        led_num = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, strip_len(strip)))
                                              : 8'($urandom_range(0, 255));
        bright  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(0, 255));
        drive_item(kind, strip, 4'($urandom_range(0, 15)), led_num, bright);
        sent++;
      end else if (r < 80) begin
        // walk the clock strip to its last LED, then switch to a drum mid-frame
        while (sb.send_pos != 4'(CLK_STRIP_LEDS_DEF - 1)) begin
          drive_update(STRIP_CLOCK);
          sent++;
        end
        drive_update(3'($urandom_range(0, 2)));
        sent++;
      end else begin
        drive_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed part with the reset end frame
    drive_item(KIND_UPDATE, 3'd0, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_CLEAR, 3'd0, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_CLEAR, 3'd1, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_CLEAR, 3'd2, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_CLEAR, STRIP_CLOCK, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_BRIGHT, STRIP_CLOCK, COLOR_RED, 8'd0, 8'd31);
    drive_item(KIND_BRIGHT, 3'd0, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_BRIGHT, 3'd1, COLOR_RED, 8'd0, 8'd32);
    drive_item(KIND_BRIGHT, 3'd2, COLOR_RED, 8'd0, 8'd255);
    drive_item(KIND_SET_ONE, STRIP_CLOCK, COLOR_PINK, 8'd10, 8'd0);
    drive_item(KIND_SET_ONE, 3'd0, COLOR_RED, 8'd1, 8'd0);
    drive_item(KIND_SET_ONE, 3'd1, COLOR_WHITE, 8'd0, 8'd0);
    drive_item(KIND_SET_ONE, 3'd0, COLOR_YELLOW, 8'd10, 8'd0);
    drive_item(KIND_SET_ONE, 3'd2, 4'd15, 8'd255, 8'd255);
    drive_item(KIND_SET_ALL, 3'd1, COLOR_PINK, 8'd0, 8'd0);
    drive_item(KIND_SET_ALL, 3'd2, 4'd8, 8'd0, 8'd0);
    drive_item(KIND_SET_ALL, STRIP_CLOCK, COLOR_TURQUOISE, 8'd0, 8'd0);
    drive_item(KIND_CLEAR, 3'd4, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_UPDATE, 3'd7, COLOR_RED, 8'd0, 8'd0);
    drive_item(3'd5, 3'd0, COLOR_RED, 8'd0, 8'd0);
    drive_item(3'd7, STRIP_CLOCK, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_UPDATE, 3'd1, COLOR_RED, 8'd0, 8'd0);
    drive_item(KIND_UPDATE, 3'd1, COLOR_RED, 8'd0, 8'd0);

    write_end_frame(32'h0000_0000);
    tx_quiet = 1'b1;
    run_random(70);
    write_end_frame(32'($urandom()));
    tx_quiet = 1'b0;
    rx_quiet = 1'b1;
    run_random(70);
    write_end_frame(32'h8000_0001);
    rx_quiet = 1'b0;
    run_random(70);
    write_end_frame(32'hFFFF_FFFF);
    run_random(70);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
